// File: src/sdla_pkg.sv
// Shared types and constants for the sprite directional light accumulator.
package sdla_pkg;

	localparam logic [7:0] WHITE = 8'hff;
	localparam int QBITS = 15;
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_APPLY = 1'b1;
	localparam logic [12:0] MAX_RADIUS_RESET = 13'd256;

	typedef struct packed {
		logic               command;
		logic [7:0]         color_r;
		logic [7:0]         color_g;
		logic [7:0]         color_b;
		logic signed [15:0] view_x;
		logic signed [15:0] view_y;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic [30:0]        distance;
		logic signed [31:0] height_diff;
		logic [30:0]        light_radius;
	} in_item_t;

	typedef struct packed {
		logic [7:0] left_r;
		logic [7:0] left_g;
		logic [7:0] left_b;
		logic [7:0] right_r;
		logic [7:0] right_g;
		logic [7:0] right_b;
		logic       stop;
	} out_item_t;

	// what the front stage decided about an item
	typedef enum logic [1:0] {
		K_BEGIN,
		K_SKIP,
		K_LIGHT
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         color_r;
		logic [7:0]         color_g;
		logic [7:0]         color_b;
		logic signed [15:0] view_x;
		logic signed [15:0] view_y;
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic [30:0]        distance;
		logic [30:0]        hd_abs;
		logic [30:0]        light_radius;
		logic [12:0]        radius;
	} work_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVZ,
		S_DIVF,
		S_DIVX,
		S_DIVY,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_ADD,
		S_OUT
	} back_state_t;

endpackage

// File: src/sdla_divider.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend over 31-bit divisor.
module sdla_divider import sdla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);

	logic [47:0] q_q;
	logic [31:0] rem_q;
	logic [30:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], q_q[47]};
	assign trial = {1'b0, shifted} - {2'b00, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;

endmodule

// File: src/sdla_front.sv
// Front stage: classifies an item and pushes it into a two-entry work queue.
module sdla_front import sdla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	input  logic [12:0] max_radius,
	input  logic      pop_work,
	output logic      work_valid,
	output work_t     work
);

	work_t       mem_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	work_t       w;
	logic [31:0] hd_abs;
	logic [12:0] r;
	logic        do_push, do_pop;

	always_comb begin
		r = (max_radius == '0) ? 13'd1 : max_radius;
		hd_abs = item.height_diff[31] ? 32'(-item.height_diff) : 32'(item.height_diff);
		w.color_r = item.color_r;
		w.color_g = item.color_g;
		w.color_b = item.color_b;
		w.view_x = item.view_x;
		w.view_y = item.view_y;
		w.offset_x = item.offset_x;
		w.offset_y = item.offset_y;
		w.distance = item.distance;
		w.hd_abs = hd_abs[30:0];
		w.light_radius = (item.light_radius == '0) ? 31'd1 : item.light_radius;
		w.radius = r;
		if (item.command == CMD_BEGIN)
			w.kind = K_BEGIN;
		else if (item.distance == '0 || {16'd0, hd_abs} > {19'd0, r, 16'd0})
			w.kind = K_SKIP;
		else
			w.kind = K_LIGHT;
	end

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign work_valid = (cnt_q != 2'd0);
	assign do_pop = pop_work && work_valid;
	assign work = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= w;
	end

endmodule

// File: src/sdla_back.sv
// Back stage: light math with a shared divider, accumulators and the result register.
module sdla_back import sdla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      work_valid,
	input  work_t     work,
	output logic      pop_work,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	back_state_t state_q, state_d;
	work_t       w_q;
	logic [7:0]  lc_q [3];
	logic [7:0]  rc_q [3];
	logic signed [15:0] vx_q, vy_q;
	logic signed [16:0] z_q, f_q, lx_q, ly_q;
	logic signed [16:0] zf_q;
	logic signed [17:0] dir_q, side_q, inl_q, inr_q;
	logic signed [33:0] p1_q, p2_q;
	logic        res_valid_q;
	logic        div_start, div_done;
	logic [47:0] div_num, div_quot;
	logic [30:0] div_den;
	logic        white;
	logic        neg_q;

	sdla_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_quot)
	);

	assign white = (lc_q[0] == WHITE) && (lc_q[1] == WHITE) && (lc_q[2] == WHITE) &&
		(rc_q[0] == WHITE) && (rc_q[1] == WHITE) && (rc_q[2] == WHITE);
	assign empty = !res_valid_q;

	function automatic logic signed [16:0] sat_q(input logic neg, input logic [47:0] q);
		logic signed [16:0] m;
		begin
			m = (q > 48'd32768) ? 17'sd32768 : 17'(q);
			return neg ? -m : m;
		end
	endfunction

	function automatic logic signed [17:0] floor15(input logic signed [33:0] v);
		logic signed [33:0] s;
		begin
			s = v >>> QBITS;
			return s[17:0];
		end
	endfunction

	// amt is at most 2.0 in Q15 when positive
	function automatic logic [7:0] addc(input logic [7:0] acc, input logic signed [17:0] amt,
		input logic [7:0] c);
		logic [24:0] p;
		logic [9:0]  t;
		begin
			p = 25'(amt[16:0]) * 25'(c);
			t = 10'(acc) + 10'(p >> QBITS);
			if (amt <= 0) return acc;
			return (t > 10'd255) ? WHITE : t[7:0];
		end
	endfunction

	// divider operand select by state
	always_comb begin
		logic [31:0] ax, ay;
		ax = w_q.offset_x[31] ? 32'(-w_q.offset_x) : 32'(w_q.offset_x);
		ay = w_q.offset_y[31] ? 32'(-w_q.offset_y) : 32'(w_q.offset_y);
		div_num = '0;
		div_den = 31'd1;
		case (state_d)
			S_DIVZ: begin
				div_num = 48'(work.hd_abs);
				div_den = {17'd0, work.radius, 1'b0};
			end
			S_DIVF: begin
				div_num = {3'd0, w_q.distance, 14'd0};
				div_den = w_q.light_radius;
			end
			S_DIVX: begin
				div_num = {1'b0, ax, 15'd0};
				div_den = w_q.distance;
			end
			S_DIVY: begin
				div_num = {1'b0, ay, 15'd0};
				div_den = w_q.distance;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		pop_work = 1'b0;
		case (state_q)
			S_IDLE: if (work_valid && !res_valid_q) begin
				pop_work = 1'b1;
				if (work.kind == K_LIGHT && !white) begin
					state_d = S_DIVZ;
					div_start = 1'b1;
				end else
					state_d = S_OUT;
			end
			S_DIVZ: if (div_done) begin state_d = S_DIVF; div_start = 1'b1; end
			S_DIVF: if (div_done) begin state_d = S_DIVX; div_start = 1'b1; end
			S_DIVX: if (div_done) begin state_d = S_DIVY; div_start = 1'b1; end
			S_DIVY: if (div_done) state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_MUL4;
			S_MUL4: state_d = S_ADD;
			S_ADD:  state_d = S_OUT;
			S_OUT:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// first division starts while w_q still holds the previous item, so it reads the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lc_q[i] <= '0;
				rc_q[i] <= '0;
			end
			vx_q <= '0;
			vy_q <= '0;
			result <= '0;
		end else begin
			state_q <= state_d;
			if (res_valid_q && pop) res_valid_q <= 1'b0;
			if (state_q == S_IDLE && pop_work && work.kind == K_BEGIN) begin
				lc_q[0] <= work.color_r; lc_q[1] <= work.color_g; lc_q[2] <= work.color_b;
				rc_q[0] <= work.color_r; rc_q[1] <= work.color_g; rc_q[2] <= work.color_b;
				vx_q <= work.view_x;
				vy_q <= work.view_y;
			end
			if (state_q == S_ADD) begin
				lc_q[0] <= addc(lc_q[0], inl_q, w_q.color_r);
				lc_q[1] <= addc(lc_q[1], inl_q, w_q.color_g);
				lc_q[2] <= addc(lc_q[2], inl_q, w_q.color_b);
				rc_q[0] <= addc(rc_q[0], inr_q, w_q.color_r);
				rc_q[1] <= addc(rc_q[1], inr_q, w_q.color_g);
				rc_q[2] <= addc(rc_q[2], inr_q, w_q.color_b);
			end
			if (state_q == S_OUT) begin
				res_valid_q <= 1'b1;
				result.left_r <= lc_q[0]; result.left_g <= lc_q[1]; result.left_b <= lc_q[2];
				result.right_r <= rc_q[0]; result.right_g <= rc_q[1];
				result.right_b <= rc_q[2];
				result.stop <= neg_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [33:0] pl, pr;
		if (state_q == S_IDLE && pop_work) begin
			w_q <= work;
			// white is checked ahead of the vertical range test
			neg_q <= (work.kind != K_BEGIN) && work.distance != '0 && white;
		end
		if (state_q == S_DIVZ && div_done)
			z_q <= (div_quot <= 48'd16384) ? 17'sd32768 :
				17'(2 * (32768 - div_quot[16:0]));
		if (state_q == S_DIVF && div_done)
			f_q <= (div_quot >= 48'd32768) ? 17'sd0 : 17'(48'd32768 - div_quot);
		if (state_q == S_DIVX && div_done) lx_q <= sat_q(w_q.offset_x[31], div_quot);
		if (state_q == S_DIVY && div_done) ly_q <= sat_q(w_q.offset_y[31], div_quot);
		if (state_q == S_MUL1) begin
			p1_q <= 34'(vx_q * lx_q) + 34'(vy_q * ly_q);
			p2_q <= 34'(vx_q * ly_q) - 34'(vy_q * lx_q);
			zf_q <= 17'((34'(z_q) * 34'(f_q)) >>> QBITS);
		end
		if (state_q == S_MUL2) begin
			dir_q <= floor15(p1_q);
			side_q <= floor15(p2_q);
		end
		if (state_q == S_MUL3) begin
			if (dir_q > 0) begin
				if (side_q > 0) begin inr_q <= 18'sd32768; inl_q <= dir_q; end
				else begin inl_q <= 18'sd32768; inr_q <= dir_q; end
			end else begin
				if (side_q > 0) begin inr_q <= side_q; inl_q <= '0; end
				else begin inl_q <= -side_q; inr_q <= '0; end
			end
		end
		if (state_q == S_MUL4) begin
			pl = 34'(inl_q) * 34'(zf_q);
			pr = 34'(inr_q) * 34'(zf_q);
			inl_q <= floor15(pl);
			inr_q <= floor15(pr);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop_work |-> work_valid)
		else $error("work popped from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> !empty)
		else $error("result not posted");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_OUT) |-> empty)
		else $error("busy while result waits");

endmodule

// File: src/sprite_directional_light_accumulator.sv
// Top level: config register, front classifier and back light engine.
//  channel | handshake        | payload
//  input   | push / full      | item (in_item_t)
//  result  | pop / empty      | result (out_item_t)
//  config  | APB psel/penable | max_radius at address 0
// A light item posts its result after four 48-step divisions in one shared divider,
// then the multiply steps S_MUL1 to S_MUL4, the add step S_ADD and S_OUT.
// Begin, skipped and stopped items go from S_IDLE straight to S_OUT to post their result.
// Reset clears accumulators and view vector; max_radius returns to 256.
// The front queue holds two items while the back stage works or its result waits.
module sprite_directional_light_accumulator import sdla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [12:0] max_radius_q;
	logic        work_valid, pop_work;
	work_t       work;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {19'd0, max_radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_radius_q <= MAX_RADIUS_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0)
			max_radius_q <= pwdata[12:0];
	end

	sdla_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.max_radius(max_radius_q), .pop_work(pop_work), .work_valid(work_valid),
		.work(work)
	);

	sdla_back u_back (
		.clk(clk), .arst_n(arst_n), .work_valid(work_valid), .work(work),
		.pop_work(pop_work), .empty(empty), .pop(pop), .result(result)
	);

endmodule
